FILE: hw/rtl/e2r_pkg.sv
// Package for the Euler angle to rotation matrix core.
// Holds field widths, angle constants, the arctangent table and cell types.
`timescale 1ns / 1ps
`default_nettype none
package e2r_pkg;

   localparam int ANGLE_W   = 24;
   localparam int ENTRY_W   = 16;
   localparam int STAGES    = 16;
   localparam int XY_W      = 27;
   localparam int Z_W       = 26;
   localparam int TRIG_W    = 17;

   localparam logic [16:0] FULL_TURN     = 17'd92160;
   localparam logic [16:0] HALF_TURN     = 17'd46080;
   localparam logic [16:0] QUARTER_TURN  = 17'd23040;
   localparam logic [16:0] THREE_QUARTER = 17'd69120;
   localparam logic signed [XY_W-1:0] CORDIC_GAIN = 27'sd10188014;
   localparam logic signed [TRIG_W-1:0] ONE_Q15 = 17'sd32768;

   typedef logic signed [ANGLE_W-1:0] angle_type;
   typedef logic signed [ENTRY_W-1:0] entry_type;
   typedef logic signed [TRIG_W-1:0]  trig_type;

   // One CORDIC lane inside a cell
   typedef struct packed {
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic signed [Z_W-1:0]  z;
      logic                   flip;
   } lane_type;

   typedef struct packed {
      logic     valid;
      lane_type ax;
      lane_type ay;
      lane_type az;
   } cell_type;

   function automatic logic signed [Z_W-1:0] atan_q16(input logic [4:0] i);
      logic signed [Z_W-1:0] t;
      unique case (i)
         5'd0: t = 26'sd2949120;
         5'd1: t = 26'sd1740967;
         5'd2: t = 26'sd919879;
         5'd3: t = 26'sd466945;
         5'd4: t = 26'sd234379;
         5'd5: t = 26'sd117304;
         5'd6: t = 26'sd58666;
         5'd7: t = 26'sd29335;
         5'd8: t = 26'sd14668;
         5'd9: t = 26'sd7334;
         5'd10: t = 26'sd3667;
         5'd11: t = 26'sd1833;
         5'd12: t = 26'sd917;
         5'd13: t = 26'sd458;
         5'd14: t = 26'sd229;
         5'd15: t = 26'sd115;
         5'd16: t = 26'sd57;
         5'd17: t = 26'sd29;
         5'd18: t = 26'sd14;
         5'd19: t = 26'sd7;
         5'd20: t = 26'sd4;
         5'd21: t = 26'sd2;
         5'd22: t = 26'sd1;
         default: t = 26'sd0;
      endcase
      return t;
   endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/e2r_if.sv
// Valid/ready channel interfaces for the Euler angle to rotation matrix core.
// Depends on e2r_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface e2r_req_if;
   logic                valid;
   logic                ready;
   e2r_pkg::angle_type  angle_x;
   e2r_pkg::angle_type  angle_y;
   e2r_pkg::angle_type  angle_z;
   modport source (output valid, angle_x, angle_y, angle_z, input ready);
   modport sink (input valid, angle_x, angle_y, angle_z, output ready);
endinterface

interface e2r_rsp_if;
   logic                valid;
   logic                ready;
   e2r_pkg::entry_type  row1_col1;
   e2r_pkg::entry_type  row1_col2;
   e2r_pkg::entry_type  row1_col3;
   e2r_pkg::entry_type  row2_col1;
   e2r_pkg::entry_type  row2_col2;
   e2r_pkg::entry_type  row2_col3;
   e2r_pkg::entry_type  row3_col1;
   e2r_pkg::entry_type  row3_col2;
   e2r_pkg::entry_type  row3_col3;
   modport source (output valid, row1_col1, row1_col2, row1_col3, row2_col1, row2_col2,
                   row2_col3, row3_col1, row3_col2, row3_col3, input ready);
   modport sink (input valid, row1_col1, row1_col2, row1_col3, row2_col1, row2_col2,
                 row2_col3, row3_col1, row3_col2, row3_col3, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/e2r_fold.sv
// Angle reduction: modulo 360 degrees and fold into [-90, 90] degrees.
// Registered; depends on e2r_pkg. Reduction by reciprocal multiply.
`timescale 1ns / 1ps
`default_nettype none
module e2r_fold (
   input  wire logic               clock,
   input  wire logic               enable,
   input  wire e2r_pkg::angle_type angle,
   output e2r_pkg::lane_type       lane
);
   localparam logic [16:0] FULLTURN_18 = e2r_pkg::FULL_TURN;

   // angle + 2^23 offset is non-negative; offset 8388608 mod 92160 = 2048
   logic [23:0] biased;
   logic [47:0] prod;
   logic [7:0]  quot;
   logic [30:0] qmul;
   logic [17:0] rem_raw;
   logic [17:0] rem_fix;
   logic [16:0] r;
   logic signed [17:0] folded;
   logic        flip;

   always_comb begin
      biased  = {~angle[23], angle[22:0]};
      // floor(2^32/92160) = 46603; quotient up to 182, at most one low
      prod    = 48'(biased) * 48'd46603;
      quot    = prod[39:32];
      qmul    = 31'(quot) * 31'd92160;
      rem_raw = 18'(31'(biased) - qmul);
      if (rem_raw >= {1'b0, FULLTURN_18})
         rem_raw = rem_raw - {1'b0, FULLTURN_18};
      // remove offset of 2048
      if (rem_raw >= 18'd2048) rem_fix = rem_raw - 18'd2048;
      else rem_fix = rem_raw + {1'b0, FULLTURN_18} - 18'd2048;
      r = rem_fix[16:0];
      flip = 1'b0;
      priority if (r > e2r_pkg::THREE_QUARTER) begin
         folded = $signed({1'b0, r}) - $signed({1'b0, e2r_pkg::FULL_TURN});
      end else if (r > e2r_pkg::QUARTER_TURN) begin
         folded = $signed({1'b0, r}) - $signed({1'b0, e2r_pkg::HALF_TURN});
         flip = 1'b1;
      end else begin
         folded = $signed({1'b0, r});
      end
   end

   // hold the folded lane for the first cell
   always_ff @(posedge clock) begin
      if (enable) begin
         lane.x    <= e2r_pkg::CORDIC_GAIN;
         lane.y    <= '0;
         lane.z    <= {folded, 8'd0};
         lane.flip <= flip;
      end
   end
endmodule
`default_nettype wire

FILE: hw/rtl/e2r_cell.sv
// One CORDIC rotation cell, three lanes wide, with its own stage index.
// Depends on e2r_pkg.
`timescale 1ns / 1ps
`default_nettype none
module e2r_cell (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              enable,
   input  wire logic [4:0]        index,
   input  wire e2r_pkg::cell_type cell_in,
   output e2r_pkg::cell_type      cell_out
);
   e2r_pkg::cell_type cell_in_w;
   e2r_pkg::cell_type cell_ff;

   function automatic e2r_pkg::lane_type rotate(input e2r_pkg::lane_type l,
                                                input logic [4:0] i);
      e2r_pkg::lane_type o;
      logic signed [e2r_pkg::XY_W-1:0] dx;
      logic signed [e2r_pkg::XY_W-1:0] dy;
      dx = l.y >>> i;
      dy = l.x >>> i;
      o  = l;
      if (!l.z[e2r_pkg::Z_W-1]) begin
         o.x = l.x - dx;
         o.y = l.y + dy;
         o.z = l.z - e2r_pkg::atan_q16(i);
      end else begin
         o.x = l.x + dx;
         o.y = l.y - dy;
         o.z = l.z + e2r_pkg::atan_q16(i);
      end
      return o;
   endfunction

   // advance one micro-rotation per lane
   always_comb begin
      cell_in_w       = cell_in;
      cell_in_w.ax    = rotate(cell_in.ax, index);
      cell_in_w.ay    = rotate(cell_in.ay, index);
      cell_in_w.az    = rotate(cell_in.az, index);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else if (enable) begin
         cell_ff.valid <= cell_in.valid;
      end
      if (enable) begin
         cell_ff.ax <= cell_in_w.ax;
         cell_ff.ay <= cell_in_w.ay;
         cell_ff.az <= cell_in_w.az;
      end
   end

   assign cell_out = cell_ff;
endmodule
`default_nettype wire

FILE: hw/rtl/e2r_matrix.sv
// Matrix build: rounds sines/cosines, forms the nine entries over three stages.
// Depends on e2r_pkg. Stall-controlled by enable.
`timescale 1ns / 1ps
`default_nettype none
module e2r_matrix (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              enable,
   input  wire e2r_pkg::cell_type cell_in,
   output logic                   valid,
   output e2r_pkg::entry_type     entry [9]
);
   typedef logic signed [33:0] p2_type;
   typedef logic signed [50:0] p3_type;

   function automatic e2r_pkg::trig_type round_trig(input logic signed [26:0] v,
                                                    input logic f);
      logic signed [27:0] t;
      logic signed [18:0] s;
      e2r_pkg::trig_type c;
      t = 28'(v) + 28'sd256;
      s = 19'(t >>> 9);
      if (s > 19'sd32768) c = e2r_pkg::ONE_Q15;
      else if (s < -19'sd32768) c = -e2r_pkg::ONE_Q15;
      else c = 17'(s);
      return f ? -c : c;
   endfunction

   function automatic e2r_pkg::entry_type to_q14(input p3_type v);
      p3_type t;
      logic signed [19:0] q;
      t = v + (p3_type'(1) <<< 30);
      q = 20'(t >>> 31);
      if (q > 20'sd16384) return 16'sd16384;
      if (q < -20'sd16384) return -16'sd16384;
      return 16'(q);
   endfunction

   logic [2:0] valid_ff;
   e2r_pkg::trig_type cx_ff, sx_ff, cy_ff, sy_ff, cz_ff, sz_ff;
   // stage 2: pair products and delayed factors
   p2_type cycz_ff, cysz_ff, sxsy_ff, cxsz_ff, cxcz_ff, sxcy_ff, cxsy_ff, sxsz_ff, sxcz_ff;
   p2_type cxcy_ff, sy2_ff;
   e2r_pkg::trig_type cz2_ff, sz2_ff;
   e2r_pkg::entry_type entry_ff [9];
   p3_type t0, t1, t2, t3, t4, t5;

   always_comb begin
      t0 = p3_type'(sxsy_ff) * p3_type'(cz2_ff);
      t1 = p3_type'(sxsy_ff) * p3_type'(sz2_ff);
      t2 = p3_type'(cxsy_ff) * p3_type'(cz2_ff);
      t3 = p3_type'(cxsy_ff) * p3_type'(sz2_ff);
      t4 = p3_type'(cxsz_ff) <<< 15;
      t5 = p3_type'(cxcz_ff) <<< 15;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (enable) begin
         valid_ff <= {valid_ff[1:0], cell_in.valid};
      end
      if (enable) begin
         // round CORDIC outputs
         cx_ff <= round_trig(cell_in.ax.x, cell_in.ax.flip);
         sx_ff <= round_trig(cell_in.ax.y, cell_in.ax.flip);
         cy_ff <= round_trig(cell_in.ay.x, cell_in.ay.flip);
         sy_ff <= round_trig(cell_in.ay.y, cell_in.ay.flip);
         cz_ff <= round_trig(cell_in.az.x, cell_in.az.flip);
         sz_ff <= round_trig(cell_in.az.y, cell_in.az.flip);
         // pair products
         cycz_ff <= 34'(cy_ff * cz_ff);
         cysz_ff <= 34'(cy_ff * sz_ff);
         sxsy_ff <= 34'(sx_ff * sy_ff);
         cxsz_ff <= 34'(cx_ff * sz_ff);
         cxcz_ff <= 34'(cx_ff * cz_ff);
         sxcy_ff <= 34'(sx_ff * cy_ff);
         cxsy_ff <= 34'(cx_ff * sy_ff);
         sxsz_ff <= 34'(sx_ff * sz_ff);
         sxcz_ff <= 34'(sx_ff * cz_ff);
         cxcy_ff <= 34'(cx_ff * cy_ff);
         sy2_ff  <= 34'(p2_type'(sy_ff) <<< 15);
         cz2_ff  <= cz_ff;
         sz2_ff  <= sz_ff;
         // third factor and rounding
         entry_ff[0] <= to_q14(p3_type'(cycz_ff) <<< 15);
         entry_ff[1] <= to_q14(p3_type'(cysz_ff) <<< 15);
         entry_ff[2] <= to_q14(-(p3_type'(sy2_ff) <<< 15));
         entry_ff[3] <= to_q14(t0 - t4);
         entry_ff[4] <= to_q14(t1 + t5);
         entry_ff[5] <= to_q14(p3_type'(sxcy_ff) <<< 15);
         entry_ff[6] <= to_q14(t2 + (p3_type'(sxsz_ff) <<< 15));
         entry_ff[7] <= to_q14(t3 - (p3_type'(sxcz_ff) <<< 15));
         entry_ff[8] <= to_q14(p3_type'(cxcy_ff) <<< 15);
      end
   end

   assign valid = valid_ff[2];
   assign entry = entry_ff;
endmodule
`default_nettype wire

FILE: hw/rtl/euler_to_rotation_matrix_core.sv
// Euler X/Y/Z angles to 3x3 rotation matrix (Rx*Ry*Rz), Q2.14 entries.
// Channels: req (angle_x/y/z, degrees with 8 fraction bits) and rsp (nine
// row-major entries, clamped to [-1, 1]), both valid/ready; a beat moves on
// valid and ready high at a clock edge.
// Throughput: one beat per cycle while the receiver does not stall. Pipeline:
// 21 register stages (1 fold stage, 16 CORDIC cells, 3 matrix stages, 1 output
// register); a request beat passes through them in that order before rsp.valid
// rises.
// The whole pipeline advances only when the output register is empty or its
// beat is taken, so a stalled receiver freezes the chain and deasserts
// req.ready; no beat is dropped.
// Synchronous reset clears all valid bits and holds req.ready low; req.ready
// rises combinationally as soon as reset falls. No configuration.
// Depends on e2r_pkg, e2r_if, e2r_fold, e2r_cell, e2r_matrix.
`timescale 1ns / 1ps
`default_nettype none
module euler_to_rotation_matrix_core (
   input  wire logic  clock,
   input  wire logic  reset,
   e2r_req_if.sink    req,
   e2r_rsp_if.source  rsp
);
   localparam int N = e2r_pkg::STAGES;

   logic enable;
   logic fold_valid_ff;
   e2r_pkg::cell_type chain [N+1];
   e2r_pkg::lane_type fx, fy, fz;
   logic mat_valid;
   e2r_pkg::entry_type mat_entry [9];
   logic out_valid_ff;
   e2r_pkg::entry_type out_ff [9];

   // advance when output slot is free or being drained
   assign enable    = !out_valid_ff || rsp.ready;
   assign req.ready = enable && !reset;

   e2r_fold u_fold_x (.clock(clock), .enable(enable), .angle(req.angle_x), .lane(fx));
   e2r_fold u_fold_y (.clock(clock), .enable(enable), .angle(req.angle_y), .lane(fy));
   e2r_fold u_fold_z (.clock(clock), .enable(enable), .angle(req.angle_z), .lane(fz));

   always_ff @(posedge clock) begin
      if (reset) fold_valid_ff <= 1'b0;
      else if (enable) fold_valid_ff <= req.valid;
   end

   assign chain[0] = '{valid: fold_valid_ff, ax: fx, ay: fy, az: fz};

   // chain of rotation cells
   for (genvar g = 0; g < N; g++) begin : g_cell
      e2r_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .enable  (enable),
         .index   (5'(g)),
         .cell_in (chain[g]),
         .cell_out(chain[g+1])
      );
   end

   e2r_matrix u_matrix (
      .clock  (clock),
      .reset  (reset),
      .enable (enable),
      .cell_in(chain[N]),
      .valid  (mat_valid),
      .entry  (mat_entry)
   );

   // hold the response beat
   always_ff @(posedge clock) begin
      if (reset) out_valid_ff <= 1'b0;
      else if (enable) out_valid_ff <= mat_valid;
      if (enable) out_ff <= mat_entry;
   end

   assign rsp.valid     = out_valid_ff;
   assign rsp.row1_col1 = out_ff[0];
   assign rsp.row1_col2 = out_ff[1];
   assign rsp.row1_col3 = out_ff[2];
   assign rsp.row2_col1 = out_ff[3];
   assign rsp.row2_col2 = out_ff[4];
   assign rsp.row2_col3 = out_ff[5];
   assign rsp.row3_col1 = out_ff[6];
   assign rsp.row3_col2 = out_ff[7];
   assign rsp.row3_col3 = out_ff[8];
endmodule
`default_nettype wire

FILE: bench/tb_scoreboard.sv
// Scoreboard for the Euler angle to rotation matrix core testbench.
// Predicts the nine Q2.14 entries per angle beat; depends on e2r_pkg.
`timescale 1ns / 1ps
`default_nettype none
package tb_scoreboard_pkg;

   typedef struct packed {
      e2r_pkg::entry_type [8:0] entry;
   } matrix_type;

   class matrix_scoreboard;
      matrix_type pending_matrices[$];
      int         mismatches;

      static function longint floor_shr(longint v, int s);
         return v >>> s;
      endfunction

      static function longint clamp(longint v, longint lim);
         if (v > lim) return lim;
         if (v < -lim) return -lim;
         return v;
      endfunction

      // CORDIC sine and cosine of a degree angle with 8 fraction bits, Q15
      static function void trig(e2r_pkg::angle_type ang, output longint c, output longint s);
         longint r, z, x, y, dx, dy, t;
         bit     flip;
         r = longint'(ang) % 92160;
         flip = 0;
         if (r < 0) r += 92160;
         if (r > 69120) begin
            r -= 92160;
         end else if (r > 23040) begin
            r -= 46080;
            flip = 1;
         end
         z = r * 256;
         x = 10188014;
         y = 0;
         for (int i = 0; i < e2r_pkg::STAGES && i < 24; i++) begin
            dx = floor_shr(y, i);
            dy = floor_shr(x, i);
            t = longint'(e2r_pkg::atan_q16(i[4:0]));
            if (z >= 0) begin
               x -= dx; y += dy; z -= t;
            end else begin
               x += dx; y -= dy; z += t;
            end
         end
         c = clamp(floor_shr(x + 256, 9), 32768);
         s = clamp(floor_shr(y + 256, 9), 32768);
         if (flip) begin
            c = -c;
            s = -s;
         end
      endfunction

      static function e2r_pkg::entry_type to_entry(longint v);
         return e2r_pkg::entry_type'(clamp(floor_shr(v + (64'sd1 <<< 30), 31), 16384));
      endfunction

      // Note an accepted angle beat and queue its rotation matrix
      function void note_angles(e2r_pkg::angle_type ax, e2r_pkg::angle_type ay,
                                e2r_pkg::angle_type az);
         longint cx, sx, cy, sy, cz, sz, k;
         matrix_type m;
         k = 32768;
         trig(ax, cx, sx);
         trig(ay, cy, sy);
         trig(az, cz, sz);
         m.entry[0] = to_entry(cy * cz * k);
         m.entry[1] = to_entry(cy * sz * k);
         m.entry[2] = to_entry(-sy * k * k);
         m.entry[3] = to_entry(sx * sy * cz - cx * sz * k);
         m.entry[4] = to_entry(sx * sy * sz + cx * cz * k);
         m.entry[5] = to_entry(sx * cy * k);
         m.entry[6] = to_entry(cx * sy * cz + sx * sz * k);
         m.entry[7] = to_entry(cx * sy * sz - sx * cz * k);
         m.entry[8] = to_entry(cx * cy * k);
         pending_matrices.push_back(m);
      endfunction

      // Compare a result beat with the oldest pending matrix
      function void check_matrix(matrix_type got);
         matrix_type want;
         if (pending_matrices.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result beat %h", got);
            return;
         end
         want = pending_matrices.pop_front();
         for (int i = 0; i < 9; i++) begin
            if (got.entry[i] !== want.entry[i]) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("entry %0d: expected %0d got %0d", i, want.entry[i], got.entry[i]);
            end
         end
      endfunction
   endclass
endpackage
`default_nettype wire

FILE: bench/tb.sv
// Top-level testbench for euler_to_rotation_matrix_core.
// Drives angle beats in bursts, stalls the result side, checks each matrix.
// Depends on e2r_pkg, e2r_if, tb_scoreboard_pkg and the core RTL.
`timescale 1ns / 1ps
`default_nettype none
module tb;

   localparam int LATENCY = 21;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int RANDOM_BEATS = 1030;

   logic clock = 0;
   logic reset = 1;
   int   idle_cycles = 0;
   bit   long_hold = 0;
   tb_scoreboard_pkg::matrix_scoreboard board = new();

   e2r_req_if req();
   e2r_rsp_if rsp();

   euler_to_rotation_matrix_core dut (.clock(clock), .reset(reset), .req(req), .rsp(rsp));

   always #10 clock = ~clock;

   initial begin
      req.valid = 0;
      req.angle_x = '0;
      req.angle_y = '0;
      req.angle_z = '0;
      rsp.ready = 0;
   end

   // Note accepted beats and check results at each edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req.valid && req.ready)
            board.note_angles(req.angle_x, req.angle_y, req.angle_z);
         if (rsp.valid && rsp.ready)
            board.check_matrix({rsp.row3_col3, rsp.row3_col2, rsp.row3_col1,
                                rsp.row2_col3, rsp.row2_col2, rsp.row2_col1,
                                rsp.row1_col3, rsp.row1_col2, rsp.row1_col1});
         if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
      end
   end

   // Watchdog on cycles without any accepted beat
   always @(posedge clock) begin
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: done, errors");
         $finish;
      end
   end

   // Receiver stall pattern, plus a long hold-off each time one is raised
   initial begin
      int phase;
      phase = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp.ready <= 0;
            repeat (120) @(posedge clock);
            long_hold = 0;
         end
         phase++;
         if ((phase / 64) % 3 == 0) rsp.ready <= 1;
         else rsp.ready <= ((phase % 7) != 3) && ($urandom_range(0, 3) != 0);
      end
   end

   function automatic e2r_pkg::angle_type pick_angle();
      case ($urandom_range(0, 5))
         0: return e2r_pkg::angle_type'($urandom);
         1: return e2r_pkg::angle_type'($urandom_range(0, 92160 * 2))
                   - e2r_pkg::angle_type'(92160);
         2: return e2r_pkg::angle_type'(23040 * $urandom_range(0, 15))
                   - e2r_pkg::angle_type'(23040 * 8)
                   + e2r_pkg::angle_type'($urandom_range(0, 2)) - e2r_pkg::angle_type'(1);
         3: return $urandom_range(0, 1)
                   ? 24'sh7FFFFF - e2r_pkg::angle_type'($urandom_range(0, 3))
                   : 24'sh800000 + e2r_pkg::angle_type'($urandom_range(0, 3));
         default: return e2r_pkg::angle_type'($urandom_range(0, 92159));
      endcase
   endfunction

   // Offer one beat and hold it until accepted
   task automatic send_angles(e2r_pkg::angle_type ax, e2r_pkg::angle_type ay,
                              e2r_pkg::angle_type az);
      req.valid <= 1;
      req.angle_x <= ax;
      req.angle_y <= ay;
      req.angle_z <= az;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
   endtask

   task automatic drop_valid();
      req.valid <= 0;
   endtask

   initial begin
      e2r_pkg::angle_type corner[12];
      int burst, wait_cycles;
      corner = '{24'sh000000, 24'sh7FFFFF, 24'sh800000, 24'sd23040, 24'sd23041,
                 24'sd46080, 24'sd69120, 24'sd69121, 24'sd92160, -24'sd23040,
                 -24'sd1, 24'sd11520};
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // Directed: corner angles on each axis, then all together
      for (int i = 0; i < 12; i++) send_angles(corner[i], corner[(i + 3) % 12],
                                               corner[(i + 7) % 12]);
      for (int i = 0; i < 12; i++) send_angles(corner[i], corner[i], corner[i]);
      // Random bursts; raise a long receiver hold partway through
      for (int n = 0; n < RANDOM_BEATS;) begin
         burst = $urandom_range(1, 40);
         if (n >= 300 && n < 340) long_hold = 1;
         for (int b = 0; b < burst && n < RANDOM_BEATS; b++, n++)
            send_angles(pick_angle(), pick_angle(), pick_angle());
         wait_cycles = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
         if (wait_cycles != 0) begin
            drop_valid();
            repeat (wait_cycles) @(posedge clock);
         end
      end
      drop_valid();
      // Drain
      while (board.pending_matrices.size() != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
      if (board.mismatches == 0) $display("tb: done, clean");
      else $display("tb: done, errors");
      $finish;
   end
endmodule
`default_nettype wire

FILE: files.f
hw/rtl/e2r_pkg.sv
hw/rtl/e2r_if.sv
hw/rtl/e2r_fold.sv
hw/rtl/e2r_cell.sv
hw/rtl/e2r_matrix.sv
hw/rtl/euler_to_rotation_matrix_core.sv
bench/tb_scoreboard.sv
bench/tb.sv
